[rtl/lfrfid_pkg.sv]
package lfrfid_pkg;

    localparam int WINDOW_BITS = 136;
    localparam int CYCLE_W     = 12;
    localparam int PULSE_W     = 16;
    localparam int SHORT_W     = 12;
    localparam int DUR_W       = 16;
    localparam int ID_W        = 32;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;

    // numerator 2*dur + cycle and divisor 2*cycle
    localparam int NUM_W = DUR_W + 2;
    localparam int DEN_W = CYCLE_W + 1;
    localparam int CNT_W = 4;

    localparam logic [CNT_W-1:0] LONG_RUN       = 4'd9;
    localparam logic [CNT_W-1:0] PREAMBLE_CELLS = 4'd8;

    localparam int DATA_START = 39;
    localparam int CELL_BITS  = 10;
    localparam int DATA_CELLS = 9;
    localparam int ID_DIGITS  = 8;

    localparam logic [7:0] FRAME_MARK = 8'hFF;
    localparam logic [7:0] START_CHAR = 8'h02;

    localparam logic [CYCLE_W-1:0] CYCLE_RST     = 12'd256;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 16'd4000;
    localparam logic [SHORT_W-1:0] SHORT_MIN_RST = 12'd60;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd2;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] cells;
    } t_cnt_res;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_COUNT  = 5'b00010,
        ST_PUSH   = 5'b00100,
        ST_CHECK  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    function automatic logic [3:0] hex_nibble(input logic [6:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 7'h30 && c <= 7'h39) begin
            v = 4'(c - 7'h30);
        end else if (c >= 7'h41 && c <= 7'h46) begin
            v = 4'(c - 7'h37);
        end
        return v;
    endfunction

endpackage

[rtl/lfrfid_cell_count.sv]
module lfrfid_cell_count (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lfrfid_pkg::NUM_W-1:0]  i_num,
    input  logic [lfrfid_pkg::DEN_W-1:0]  i_den,
    output lfrfid_pkg::t_cnt_res          o_res
);
    import lfrfid_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic             n_take;

    // one subtraction of the divisor per cycle, stopping once the count is long
    assign n_take = (r_rem >= NUM_W'(r_den)) && (r_cnt != LONG_RUN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (n_take) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy && n_take) begin
            r_rem <= r_rem - NUM_W'(r_den);
        end
    end

    assign o_res.done  = r_done;
    assign o_res.cells = r_cnt;

endmodule

[rtl/lf_rfid_ascii_hex_frame_decoder.sv]
// Decoder for framed ascii hex ids from a 125 kHz direct-modulation tag. Each input item is one
// demodulated run (level, duration in us) and gives exactly one result item: frame_valid, the
// last decoded card_id and the preamble flag. Runs are converted to a bit-cell count by
// repeated subtraction of 2*cycle_us, one per cycle; the cells then enter the 136-bit window
// one per cycle (up to 8), followed by the frame check state and the state that hands over the
// result. Runs longer than the maximum pulse, and runs that push no cells, go straight to the
// hand-over state, where the result waits while i_out_stall holds it; a new item is taken once
// the previous one has reached the output register. Configuration is written through i_cfg_we/
// i_cfg_idx/i_cfg_data; the user must write it only while idle, as the block does not enforce
// this; indexes above 2 are ignored and a cycle_us of 0 acts as 1.
module lf_rfid_ascii_hex_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lfrfid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [lfrfid_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_level,
    input  logic [lfrfid_pkg::DUR_W-1:0]      i_duration_us,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_frame_valid,
    output logic [lfrfid_pkg::ID_W-1:0]       o_card_id,
    output logic                              o_preamble_seen
);
    import lfrfid_pkg::*;

    t_state r_state;

    logic [CYCLE_W-1:0]     r_cycle;
    logic [PULSE_W-1:0]     r_max_pulse;
    logic [SHORT_W-1:0]     r_short_min;

    logic [WINDOW_BITS-1:0] r_win;
    logic                   r_pre;
    logic                   r_inv;
    logic [ID_W-1:0]        r_last_id;

    logic                   r_level;
    logic [DUR_W-1:0]       r_dur;
    logic                   r_bit;
    logic [CNT_W-1:0]       r_push_cnt;
    logic                   r_hit;

    logic                   r_out_valid;
    logic                   r_frame_valid;
    logic [ID_W-1:0]        r_card_id;
    logic                   r_pre_out;

    logic                   n_accept;
    logic                   n_start;
    logic [CYCLE_W-1:0]     n_cyc;
    logic [NUM_W-1:0]       n_num;
    logic [DEN_W-1:0]       n_den;
    t_cnt_res               n_cnt;
    logic [CNT_W-1:0]       n_push;
    logic                   n_frame_ok;
    logic [ID_W-1:0]        n_id;
    logic                   n_out_free;

    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_out_free = !r_out_valid || !i_out_stall;
    assign n_start    = n_accept && (i_duration_us <= r_max_pulse);

    assign n_cyc = (r_cycle == '0) ? CYCLE_W'(1) : r_cycle;
    assign n_num = {1'b0, i_duration_us, 1'b0} + NUM_W'(n_cyc);
    assign n_den = {n_cyc, 1'b0};

    lfrfid_cell_count u_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_num   (n_num),
        .i_den   (n_den),
        .o_res   (n_cnt)
    );

    // cells to push once the count is known
    always_comb begin
        n_push = '0;
        if (n_cnt.cells == LONG_RUN) begin
            n_push = r_pre ? '0 : PREAMBLE_CELLS;
        end else if (n_cnt.cells == '0) begin
            n_push = (r_dur > DUR_W'(r_short_min)) ? CNT_W'(1) : '0;
        end else begin
            n_push = n_cnt.cells;
        end
    end

    // frame layout check on fixed window taps, oldest cell at index 0
    always_comb begin
        logic [7:0] ch;
        logic [6:0] sum;
        n_frame_ok = (r_win[7:0] == FRAME_MARK) && !r_win[8] && !r_win[9] && r_win[10];
        for (int k = 0; k < 8; k++) begin
            if (r_win[11 + k] != START_CHAR[7 - k]) begin
                n_frame_ok = 1'b0;
            end
            if (r_win[WINDOW_BITS - 8 + k] != FRAME_MARK[7 - k]) begin
                n_frame_ok = 1'b0;
            end
        end
        sum = '0;
        ch  = '0;
        for (int i = 0; i < DATA_CELLS; i++) begin
            ch = r_win[DATA_START + CELL_BITS * i +: 8];
            // odd parity over the 7 data bits plus the parity bit
            if (!(^ch)) begin
                n_frame_ok = 1'b0;
            end
            if (i < DATA_CELLS - 1) begin
                sum = sum ^ ch[6:0];
            end
        end
        if (ch[6:0] != sum) begin
            n_frame_ok = 1'b0;
        end
    end

    always_comb begin
        n_id = '0;
        for (int i = 0; i < ID_DIGITS; i++) begin
            n_id[ID_W - 1 - 4 * i -: 4] = hex_nibble(r_win[DATA_START + CELL_BITS * i +: 7]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle     <= CYCLE_RST;
            r_max_pulse <= MAX_PULSE_RST;
            r_short_min <= SHORT_MIN_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CYCLE:     r_cycle     <= i_cfg_data[CYCLE_W-1:0];
                CFG_MAX_PULSE: r_max_pulse <= i_cfg_data[PULSE_W-1:0];
                CFG_SHORT_MIN: r_short_min <= i_cfg_data[SHORT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_win         <= '0;
            r_pre         <= 1'b0;
            r_inv         <= 1'b0;
            r_last_id     <= '0;
            r_push_cnt    <= '0;
            r_hit         <= 1'b0;
            r_out_valid   <= 1'b0;
            r_frame_valid <= 1'b0;
            r_pre_out     <= 1'b0;
        end else begin
            if (r_state == ST_FINISH && n_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (n_accept) begin
                        r_hit   <= 1'b0;
                        r_state <= n_start ? ST_COUNT : ST_FINISH;
                    end
                end
                ST_COUNT: begin
                    if (n_cnt.done) begin
                        r_push_cnt <= n_push;
                        // preamble cells always come out as ones
                        r_bit      <= (n_cnt.cells == LONG_RUN && !r_pre) ? 1'b1
                                                                          : (r_level ^ r_inv);
                        if (n_cnt.cells == LONG_RUN) begin
                            r_pre <= !r_pre;
                            if (!r_pre) begin
                                r_inv <= !r_level;
                            end
                        end
                        r_state <= (n_push == '0) ? ST_FINISH : ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    r_win      <= {r_bit, r_win[WINDOW_BITS-1:1]};
                    r_push_cnt <= r_push_cnt - 1'b1;
                    if (r_push_cnt == CNT_W'(1)) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_hit <= n_frame_ok;
                    if (n_frame_ok) begin
                        r_last_id <= n_id;
                    end
                    r_state <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (n_out_free) begin
                        r_frame_valid <= r_hit;
                        r_pre_out     <= r_pre;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_accept) begin
            r_level <= i_level;
            r_dur   <= i_duration_us;
        end
        if (r_state == ST_FINISH && n_out_free) begin
            r_card_id <= r_last_id;
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_frame_valid   = r_frame_valid;
    assign o_card_id       = r_card_id;
    assign o_preamble_seen = r_pre_out;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> o_in_stall)
        else $error("item accepted but block still idle");

    a_push_only_in_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_PUSH) |-> (r_push_cnt == '0))
        else $error("cells left to push outside the push phase");

    a_pre_from_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_pre) |-> $past(r_state == ST_COUNT && n_cnt.done))
        else $error("preamble flag changed outside a cell count result");

    a_hit_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_hit) |-> (r_last_id == n_id))
        else $error("frame hit without matching decoded id");

endmodule

[bench/tb_lf_rfid_ascii_hex_frame_decoder.sv]
`timescale 1ns / 100ps

module tb_lf_rfid_ascii_hex_frame_decoder;
    import lfrfid_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int STALL_PCT      = 12;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
    } t_run_item;

    typedef struct packed {
        logic            frame_valid;
        logic [ID_W-1:0] card_id;
        logic            preamble_seen;
    } t_id_report;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx     = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic                 i_level       = 1'b0;
    logic [DUR_W-1:0]     i_duration_us = '0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic                 o_frame_valid;
    logic [ID_W-1:0]      o_card_id;
    logic                 o_preamble_seen;

    lf_rfid_ascii_hex_frame_decoder DUT (.*);

    // decoder state as the bench sees it
    logic [WINDOW_BITS-1:0] cell_win      = '0;
    logic                   pre_flag      = 1'b0;
    logic                   inv_flag      = 1'b0;
    logic [ID_W-1:0]        last_card     = '0;
    logic [CYCLE_W-1:0]     cycle_cfg     = CYCLE_RST;
    logic [PULSE_W-1:0]     max_pulse_cfg = MAX_PULSE_RST;
    logic [SHORT_W-1:0]     short_min_cfg = SHORT_MIN_RST;

    t_run_item  run_q[$];
    t_id_report report_q[$];
    int         n_queued    = 0;
    int         n_taken     = 0;
    int         n_errors    = 0;
    int         idle_cycles = 0;
    int         stall_pct   = STALL_PCT;
    int         hold_left   = 0;
    bit         run_taken   = 1'b0;
    bit         hold_req    = 1'b0;
    // generator view of the preamble flag and polarity
    bit         gen_pre     = 1'b0;
    bit         gen_inv     = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned cell_count(input logic [DUR_W-1:0] dur);
        int unsigned c;
        int unsigned d;
        c = (cycle_cfg == 0) ? 1 : cycle_cfg;
        d = dur;
        return (2 * d + c) / (2 * c);
    endfunction

    function automatic logic [3:0] ascii_digit(input logic [6:0] c);
        logic [3:0] v;
        v = '0;
        if (c >= 7'h30 && c <= 7'h39) begin
            v = c[3:0];
        end else if (c >= 7'h41 && c <= 7'h46) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

    function automatic bit frame_match(output logic [ID_W-1:0] id);
        logic [7:0] r;
        logic [6:0] ch;
        logic [6:0] xsum;
        int         i;
        int         k;
        bit         ok;
        ok = (cell_win[7:0] == FRAME_MARK) && (cell_win[WINDOW_BITS-1 -: 8] == FRAME_MARK)
            && (cell_win[10:8] == 3'b100);
        for (k = 0; k < 8; k++) begin
            if (cell_win[11+k] != START_CHAR[7-k]) ok = 1'b0;
        end
        id   = '0;
        xsum = '0;
        ch   = '0;
        for (i = 0; i < DATA_CELLS; i++) begin
            // characters arrive lsb first
            for (k = 0; k < 8; k++) r[k] = cell_win[DATA_START + CELL_BITS*i + k];
            ch = r[6:0];
            if (r[7] != ~^ch) ok = 1'b0;
            if (i < DATA_CELLS - 1) begin
                xsum ^= ch;
                id = {id[ID_W-5:0], ascii_digit(ch)};
            end
        end
        if (ch != xsum) ok = 1'b0;
        return ok;
    endfunction

    task automatic decode_run(input logic lvl, input logic [DUR_W-1:0] dur);
        int unsigned     cells;
        int unsigned     push;
        logic [ID_W-1:0] id;
        t_id_report      rep;
        rep.frame_valid = 1'b0;
        if (dur <= max_pulse_cfg) begin
            cells = cell_count(dur);
            push  = 0;
            if (cells >= LONG_RUN) begin
                if (!pre_flag) begin
                    push     = PREAMBLE_CELLS;
                    pre_flag = 1'b1;
                    inv_flag = !lvl;
                end else begin
                    pre_flag = 1'b0;
                end
            end else if (cells == 0) begin
                push = (dur > short_min_cfg) ? 1 : 0;
            end else begin
                push = cells;
            end
            if (push != 0) begin
                repeat (push) cell_win = {lvl ^ inv_flag, cell_win[WINDOW_BITS-1:1]};
                if (frame_match(id)) begin
                    last_card       = id;
                    rep.frame_valid = 1'b1;
                end
            end
        end
        rep.card_id       = last_card;
        rep.preamble_seen = pre_flag;
        report_q.push_back(rep);
    endtask

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] got,
                                   input logic [ID_W-1:0] want);
        n_errors++;
        $display("%0t mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // monitor: result check, input acceptance and watchdog
    always @(posedge i_clk) begin
        t_id_report want;
        bit         moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (report_q.size() == 0) begin
                    report_mismatch("unexpected item", o_card_id, '0);
                end else begin
                    want = report_q.pop_front();
                    if (o_frame_valid !== want.frame_valid)
                        report_mismatch("frame_valid", ID_W'(o_frame_valid),
                                        ID_W'(want.frame_valid));
                    if (o_card_id !== want.card_id)
                        report_mismatch("card_id", o_card_id, want.card_id);
                    if (o_preamble_seen !== want.preamble_seen)
                        report_mismatch("preamble_seen", ID_W'(o_preamble_seen),
                                        ID_W'(want.preamble_seen));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                decode_run(i_level, i_duration_us);
                n_taken++;
                run_taken = 1'b1;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t no progress on either channel", $time);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // driver for the run channel
    always @(negedge i_clk) begin
        t_run_item nxt;
        if (i_rst_n && (!i_in_valid || run_taken)) begin
            run_taken = 1'b0;
            if (run_q.size() != 0 && $urandom_range(99) >= stall_pct) begin
                nxt = run_q.pop_front();
                i_in_valid    <= 1'b1;
                i_level       <= nxt.level;
                i_duration_us <= nxt.dur;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_CYCLE:     cycle_cfg     = val[CYCLE_W-1:0];
            CFG_MAX_PULSE: max_pulse_cfg = val[PULSE_W-1:0];
            CFG_SHORT_MIN: short_min_cfg = val[SHORT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_run(input logic lvl, input int unsigned dur);
        t_run_item it;
        it.level = lvl;
        it.dur   = (dur > 65535) ? 16'hFFFF : dur[DUR_W-1:0];
        if (it.dur <= max_pulse_cfg && cell_count(it.dur) >= LONG_RUN) begin
            if (!gen_pre) gen_inv = !lvl;
            gen_pre = !gen_pre;
        end
        run_q.push_back(it);
        n_queued++;
    endtask

    // random duration that rounds to exactly n cells
    function automatic int unsigned span_for(input int unsigned n);
        int unsigned c;
        c = (cycle_cfg == 0) ? 1 : cycle_cfg;
        return n * c - c / 2 + $urandom_range(c - 1, 0);
    endfunction

    task automatic queue_frame_train();
        logic [WINDOW_BITS-1:0] fb;
        logic [6:0]             ch;
        logic [6:0]             xsum;
        int unsigned            c;
        int unsigned            d;
        int                     n;
        int                     lim;
        int                     p;
        int                     f;
        int                     nf;
        int                     i;
        int                     k;
        c = (cycle_cfg == 0) ? 1 : cycle_cfg;
        // a long run clears a stale preamble, the next one gives the leading mark
        if (gen_pre) queue_run(1'($urandom_range(1)), span_for($urandom_range(12, 9)));
        queue_run(1'($urandom_range(1)), span_for($urandom_range(12, 9)));
        nf = $urandom_range(2, 1);
        for (f = 0; f < nf; f++) begin
            for (i = 0; i < WINDOW_BITS; i++) fb[i] = 1'($urandom_range(1));
            fb[7:0]               = FRAME_MARK;
            fb[WINDOW_BITS-1 -: 8] = FRAME_MARK;
            fb[10:8]              = 3'b100;
            for (k = 0; k < 8; k++) fb[11+k] = START_CHAR[7-k];
            xsum = '0;
            for (i = 0; i < DATA_CELLS; i++) begin
                if (i == DATA_CELLS - 1) begin
                    ch = xsum;
                end else if ($urandom_range(5) == 0) begin
                    ch = 7'($urandom_range(127));
                end else begin
                    k  = $urandom_range(15);
                    ch = (k < 10) ? 7'(7'h30 + k) : 7'(7'h37 + k);
                end
                xsum ^= ch;
                for (k = 0; k < 7; k++) fb[DATA_START + CELL_BITS*i + k] = ch[k];
                fb[DATA_START + CELL_BITS*i + 7] = ~^ch;
            end
            if ($urandom_range(4) == 0) begin
                k     = $urandom_range(WINDOW_BITS - 1);
                fb[k] = ~fb[k];
            end
            // the trailing mark of one frame is the leading mark of the next
            p = 8;
            while (p < WINDOW_BITS) begin
                lim = $urandom_range(8, 1);
                n   = 1;
                while (p + n < WINDOW_BITS && fb[p+n] == fb[p] && n < lim) n++;
                if (n == 1 && short_min_cfg + 1 < c - c / 2 && $urandom_range(3) == 0) begin
                    d = $urandom_range(c - c / 2 - 1, short_min_cfg + 1);
                end else begin
                    d = span_for(n);
                end
                queue_run(fb[p] ^ gen_inv, d);
                p += n;
            end
        end
    endtask

    task automatic queue_noise(input int cnt);
        int          j;
        int unsigned d;
        for (j = 0; j < cnt; j++) begin
            case ($urandom_range(5))
                0: d = $urandom_range(65535);
                1: d = $urandom_range(short_min_cfg + 8);
                2: d = span_for($urandom_range(12, 1));
                3: d = max_pulse_cfg + $urandom_range(1);
                4: d = $urandom_range(1) ? 65535 : 0;
                default: d = span_for($urandom_range(40, 9));
            endcase
            queue_run(1'($urandom_range(1)), d);
        end
    endtask

    task automatic queue_mix(input int target);
        int start;
        start = n_queued;
        while (n_queued - start < target) begin
            if ($urandom_range(9) < 7) begin
                queue_frame_train();
            end else begin
                queue_noise($urandom_range(10, 1));
            end
        end
    endtask

    task automatic settle();
        do @(negedge i_clk); while (n_taken != n_queued || report_q.size() != 0);
        repeat (24) @(negedge i_clk);
    endtask

    initial begin
        int          ph;
        int unsigned c;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // rounding, short threshold, preamble toggling and overlong runs at reset settings
        queue_run(0, 0);
        queue_run(1, 60);
        queue_run(1, 61);
        queue_run(0, 127);
        queue_run(1, 128);
        queue_run(1, 2175);
        queue_run(1, 2176);
        queue_run(0, 2500);
        queue_run(0, 2304);
        queue_run(0, 700);
        queue_run(1, 400);
        queue_run(1, 4000);
        queue_run(0, 4001);
        queue_run(1, 65535);
        queue_run(0, 4000);
        queue_run(1, 0);
        queue_mix(40);
        settle();

        // zero cycle acts as one, so every duration is a cell count
        write_reg(CFG_CYCLE, {4'hF, 12'd0});
        write_reg(CFG_MAX_PULSE, 16'hFFFF);
        write_reg(CFG_SHORT_MIN, 16'd0);
        write_reg(CFG_SPARE, 16'($urandom_range(16'hFFFF)));
        queue_run(1, 65535);
        queue_run(0, 65535);
        queue_mix(20);
        settle();

        // widest cell, no idling on either side
        stall_pct = 0;
        write_reg(CFG_CYCLE, {4'($urandom_range(15)), 12'hFFF});
        write_reg(CFG_SHORT_MIN, {4'($urandom_range(15)), 12'hFFF});
        queue_mix(30);
        settle();
        stall_pct = STALL_PCT;

        // only zero-length runs get through
        write_reg(CFG_CYCLE, 16'd1);
        write_reg(CFG_MAX_PULSE, 16'd0);
        write_reg(CFG_SHORT_MIN, 16'd0);
        queue_noise(20);
        queue_run(1, 0);
        settle();

        for (ph = 0; ph < 3; ph++) begin
            c = $urandom_range(4095, 1);
            write_reg(CFG_CYCLE, {4'($urandom_range(15)), 12'(c)});
            write_reg(CFG_MAX_PULSE, 16'($urandom_range(65535, 13 * c)));
            write_reg(CFG_SHORT_MIN, 16'($urandom_range(1) ? $urandom_range(c / 2)
                                                            : $urandom_range(4095)));
            if (ph == 0) hold_req = 1'b1;
            queue_mix(25);
            settle();
        end

        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
